// ===== src/escape_time_fractal_iterator_macros.svh =====
// Assertion macros for the escape-time iterator.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_MACROS_SVH
// implication checked on every edge outside reset
`define ETF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ETF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/etf_pkg.sv =====
package etf_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned MagW   = 40;
  localparam int unsigned ProdW  = 64;

  typedef struct packed {
    logic signed [CoordW-1:0] z0_re;
    logic signed [CoordW-1:0] z0_im;
    logic signed [CoordW-1:0] c_re;
    logic signed [CoordW-1:0] c_im;
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } core_state_t;

  // saturate a sum to the signed 32-bit range
  function automatic logic signed [CoordW-1:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] hi;
    logic signed [ProdW-1:0] lo;
    hi = ProdW'(signed'(33'sh0_7FFF_FFFF));
    lo = -hi - ProdW'(1);
    if (v > hi) return CoordW'(hi);
    if (v < lo) return CoordW'(lo);
    return CoordW'(v);
  endfunction
endpackage

// ===== src/etf_if.sv =====
interface etf_if #(parameter int unsigned W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== src/etf_queue.sv =====
// Two-entry request queue between the front and back parts.
module etf_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (out_valid && out_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem_r[wp_r] <= in_data;
  end
endmodule

// ===== src/etf_core.sv =====
// Iteration engine: each z*z+c step is a multiply state, then a sum state.
module etf_core #(
  parameter int unsigned ITER_LIMIT = 4095,
  parameter int unsigned FRAC_BITS  = 26,
  parameter int unsigned CntW       = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  etf_pkg::point_t        pt,
  input  logic [CntW-1:0]        limit,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [CntW-1:0]        res_count,
  output logic                   res_escaped,
  output logic [etf_pkg::MagW-1:0] res_mag
);
  localparam int unsigned PW = etf_pkg::ProdW;
  localparam logic [PW-1:0] Thresh = PW'(16) << FRAC_BITS;
  localparam logic [PW-1:0] MagMax = {{(PW-etf_pkg::MagW){1'b0}}, {etf_pkg::MagW{1'b1}}};

  etf_pkg::core_state_t state_r, state_nxt;
  logic signed [31:0] re_r, im_r, cre_r, cim_r;
  logic signed [PW-1:0] rr_r, ii_r, ri_r;
  logic [CntW-1:0] cnt_r, lim_r;
  logic [PW-1:0] mag;
  logic signed [PW-1:0] d, nre, nim;

  assign mag = (PW'(rr_r) + PW'(ii_r)) >> FRAC_BITS;
  assign d   = rr_r - ii_r;
  assign nre = (d >>> FRAC_BITS) + PW'(cre_r);
  assign nim = (ri_r >>> (FRAC_BITS - 1)) + PW'(cim_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      etf_pkg::ST_IDLE: if (start) state_nxt = etf_pkg::ST_MUL;
      etf_pkg::ST_MUL:  state_nxt = etf_pkg::ST_SUM;
      etf_pkg::ST_SUM:
        if (cnt_r < lim_r && mag < Thresh) state_nxt = etf_pkg::ST_MUL;
        else state_nxt = etf_pkg::ST_DONE;
      etf_pkg::ST_DONE: if (res_ready) state_nxt = etf_pkg::ST_IDLE;
      default: state_nxt = etf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= etf_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      etf_pkg::ST_IDLE: if (start) begin
        re_r  <= pt.z0_re;
        im_r  <= pt.z0_im;
        cre_r <= pt.c_re;
        cim_r <= pt.c_im;
        cnt_r <= '0;
        lim_r <= (32'(limit) > ITER_LIMIT) ? CntW'(ITER_LIMIT) : limit;
      end
      etf_pkg::ST_MUL: begin
        rr_r <= PW'(re_r) * PW'(re_r);
        ii_r <= PW'(im_r) * PW'(im_r);
        ri_r <= PW'(re_r) * PW'(im_r);
      end
      etf_pkg::ST_SUM: if (cnt_r < lim_r && mag < Thresh) begin
        re_r  <= etf_pkg::sat32(nre);
        im_r  <= etf_pkg::sat32(nim);
        cnt_r <= cnt_r + CntW'(1);
      end else begin
        res_escaped <= (mag >= Thresh);
        res_mag     <= etf_pkg::MagW'((mag > MagMax) ? MagMax : mag);
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != etf_pkg::ST_IDLE);
  assign res_valid = (state_r == etf_pkg::ST_DONE);
  assign res_count = cnt_r;
endmodule

// ===== src/escape_time_fractal_iterator.sv =====
// Escape-time iterator (Mandelbrot/Julia recurrence) in Q6.26 fixed point.
// Channels: in (z0_re, z0_im, c_re, c_im) and out (iteration_count,
// escaped, final_mag_sq) are valid/ready; a request moves on valid & ready.
// cfg writes the 12-bit iteration limit (reset 200); write only when idle.
// Front: a two-entry queue takes input requests while the back iterates.
// Back: a core does each z*z+c step as a multiply stage, then an
// add/saturate/test stage, for N steps on a point, with N at most
// min(iteration limit, ITER_LIMIT); the core works on one point at a
// time, since each step depends on the last multiply-add result.
// The result is held in the core until out_ready; meanwhile up to two
// more requests queue up at the input, then in_ready drops.
// Reset (rst_n, synchronous) empties the queue, idles the core, and
// restores the iteration limit to 200.
module escape_time_fractal_iterator #(
  parameter int unsigned ITER_LIMIT = 4095,
  parameter int unsigned FRAC_BITS  = 26
) (
  input logic clk,
  input logic rst_n,
  etf_if.sink   in_ch,
  etf_if.sink   cfg_ch,
  etf_if.source out_ch
);
`include "escape_time_fractal_iterator_macros.svh"
  localparam int unsigned CntW = 12;
  localparam int unsigned PtW  = $bits(etf_pkg::point_t);

  logic [CntW-1:0] max_iter_r;
  logic            q_valid, core_busy, res_valid;
  logic [PtW-1:0]  q_data;
  logic [CntW-1:0] res_count;
  logic            res_escaped;
  logic [etf_pkg::MagW-1:0] res_mag;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) max_iter_r <= CntW'(200);
    else if (cfg_ch.valid) max_iter_r <= cfg_ch.data[CntW-1:0];
  end

  etf_queue #(.W(PtW)) u_queue (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data[PtW-1:0]),
    .out_valid(q_valid), .out_ready(!core_busy), .out_data(q_data)
  );

  etf_core #(.ITER_LIMIT(ITER_LIMIT), .FRAC_BITS(FRAC_BITS), .CntW(CntW)) u_core (
    .clk, .rst_n,
    .start(q_valid), .busy(core_busy), .pt(etf_pkg::point_t'(q_data)),
    .limit(max_iter_r),
    .res_valid, .res_ready(out_ch.ready),
    .res_count, .res_escaped, .res_mag
  );

  assign out_ch.valid = res_valid;
  assign out_ch.data  = {res_count, res_escaped, res_mag};

  `ETF_ASSERT_IMPL(a_out_busy, out_ch.valid, core_busy)
  `ETF_ASSERT_IMPL(a_cnt_lim, out_ch.valid && !out_ch.data[etf_pkg::MagW],
                   out_ch.data[etf_pkg::MagW+CntW:etf_pkg::MagW+1] == max_iter_r ||
                   max_iter_r > CntW'(ITER_LIMIT))
  `ETF_ASSERT_NEXT(a_hold, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule
